/* sv/sbsa_pkg.sv */
package sbsa_pkg;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_FILE  = 2'd1;
   localparam logic [1:0] ACT_EOF   = 2'd2;
   localparam logic [1:0] ACT_RX    = 2'd3;

   localparam logic [7:0] CODE_ERR  = 8'hBC;
   localparam logic [7:0] CODE_PAD  = 8'h20;
   localparam logic [7:0] CODE_HSOK = 8'h97;
   localparam logic [7:0] CODE_OK   = 8'hC8;
   localparam logic [7:0] FLAG_LAST = 8'h00;
   localparam logic [7:0] FLAG_DATA = 8'h80;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;

   localparam logic [1:0] ACK_BYTES = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_FILL  = 3'd1,
      PH_SEND  = 3'd2,
      PH_WAIT  = 3'd3,
      PH_ACKD  = 3'd4,
      PH_DONE  = 3'd5,
      PH_ABORT = 3'd6,
      PH_FAIL  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data;
      logic       tx_ready;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       accepted;
      logic [2:0] status;
   } rsp_type;

   // decoded request as it travels through the queue
   typedef struct packed {
      logic       is_start;
      logic       is_file;
      logic       is_eof;
      logic       is_rx;
      logic [7:0] data;
      logic       rx_err;
      logic       rx_hsok;
      logic       tx_ready;
   } cmd_type;

endpackage

/* sv/sbsa_front.sv */
module sbsa_front (
   input  sbsa_pkg::req_type req,
   output sbsa_pkg::cmd_type cmd
);

   always_comb begin
      cmd.is_start = 1'b0;
      cmd.is_file  = 1'b0;
      cmd.is_eof   = 1'b0;
      cmd.is_rx    = 1'b0;
      case (req.action)
         sbsa_pkg::ACT_START: cmd.is_start = 1'b1;
         sbsa_pkg::ACT_FILE:  cmd.is_file  = 1'b1;
         sbsa_pkg::ACT_EOF:   cmd.is_eof   = 1'b1;
         sbsa_pkg::ACT_RX:    cmd.is_rx    = 1'b1;
         default:             cmd.is_rx    = 1'b0;
      endcase
      // newline becomes carriage return for file bytes only
      if (req.action == sbsa_pkg::ACT_FILE && req.data == sbsa_pkg::CHAR_LF) begin
         cmd.data = sbsa_pkg::CHAR_CR;
      end else begin
         cmd.data = req.data;
      end
      cmd.rx_err   = (req.data == sbsa_pkg::CODE_ERR);
      cmd.rx_hsok  = (req.data == sbsa_pkg::CODE_HSOK);
      cmd.tx_ready = req.tx_ready;
   end

endmodule

/* sv/sbsa_queue.sv */
module sbsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sbsa_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_take,
   output sbsa_pkg::cmd_type out_cmd
);

   sbsa_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_take && out_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* sv/sbsa_back.sv */
module sbsa_back #(
   parameter int BLOCK_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  sbsa_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbsa_pkg::rsp_type rsp_data
);

   localparam int FW = $clog2(BLOCK_BYTES + 1);
   localparam int PW = $clog2(BLOCK_BYTES + 2);
   localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_BYTES + 1);
   localparam logic [FW:0]   FULL_CNT = (FW + 1)'(BLOCK_BYTES);

   logic [7:0] mem [BLOCK_BYTES];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] raddr;
   logic [PW-1:0] pos_m1;
   logic       wr_en;

   sbsa_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW:0]   fill_sum;
   logic [PW-1:0] pos_ff, pos_in, pos_cur, k;
   logic [7:0]    csum_ff, csum_in, csum_cur;
   logic          final_ff, final_in;
   logic          closing_ff, closing_in, closing_cur;
   logic [1:0]    ackp_ff, ackp_in;
   logic [7:0]    ackx_ff, ackx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sbsa_pkg::rsp_type rsp_ff, rsp_in;

   logic fire;
   logic start_ok, file_ok, eof_ok, rx_send, abort, rx_wait, rx_ackd;
   logic ack_final, ack_match, fill_full, begin_blk, act_tx, emit, last_emit;
   logic acc;
   logic [7:0] blk_byte, act_byte;

   assign fire      = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_take  = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // decode what this request does in the current phase
   always_comb begin
      start_ok  = cmd.is_start && (phase_ff inside {sbsa_pkg::PH_IDLE, sbsa_pkg::PH_DONE,
                                                    sbsa_pkg::PH_ABORT, sbsa_pkg::PH_FAIL});
      file_ok   = cmd.is_file && (phase_ff == sbsa_pkg::PH_FILL);
      eof_ok    = cmd.is_eof && (phase_ff == sbsa_pkg::PH_FILL);
      rx_send   = cmd.is_rx && (phase_ff == sbsa_pkg::PH_SEND);
      abort     = rx_send && cmd.rx_err;
      rx_wait   = cmd.is_rx && (phase_ff == sbsa_pkg::PH_WAIT);
      rx_ackd   = cmd.is_rx && (phase_ff == sbsa_pkg::PH_ACKD);
      ack_final = rx_ackd && (ackp_ff >= sbsa_pkg::ACK_BYTES);
      ack_match = (cmd.data == ackx_ff);
      fill_sum  = {1'b0, fill_ff} + (FW + 1)'(1);
      fill_full = file_ok && (fill_sum >= FULL_CNT);
      begin_blk = fill_full || eof_ok || (ack_final && ack_match && final_ff);

      phase_mid = phase_ff;
      if (start_ok) begin
         phase_mid = sbsa_pkg::PH_FILL;
      end else if (begin_blk) begin
         phase_mid = sbsa_pkg::PH_SEND;
      end else if (abort) begin
         phase_mid = sbsa_pkg::PH_ABORT;
      end else if (rx_wait) begin
         phase_mid = cmd.rx_hsok ? sbsa_pkg::PH_ACKD : sbsa_pkg::PH_FAIL;
      end else if (ack_final) begin
         phase_mid = ack_match ? sbsa_pkg::PH_FILL : sbsa_pkg::PH_FAIL;
      end

      act_tx      = rx_wait || ack_final;
      emit        = !abort && !act_tx && cmd.tx_ready && (phase_mid == sbsa_pkg::PH_SEND);
      pos_cur     = begin_blk ? '0 : pos_ff;
      csum_cur    = begin_blk ? 8'h00 : csum_ff;
      closing_cur = closing_ff || (ack_final && ack_match && final_ff);
      last_emit   = emit && (pos_cur == LAST_POS);
   end

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         phase_in = phase_mid;
         if (last_emit) begin
            phase_in = closing_cur ? sbsa_pkg::PH_DONE : sbsa_pkg::PH_WAIT;
         end
      end
   end

   always_comb begin
      k = pos_cur - PW'(1);
      if (pos_cur == '0) begin
         blk_byte = closing_cur ? sbsa_pkg::FLAG_LAST : sbsa_pkg::FLAG_DATA;
      end else if (pos_cur == LAST_POS) begin
         blk_byte = csum_cur;
      end else if (k < PW'(fill_ff)) begin
         blk_byte = rd_data_ff;
      end else begin
         blk_byte = sbsa_pkg::CODE_PAD;
      end

      if (rx_wait) begin
         act_byte = cmd.rx_hsok ? sbsa_pkg::CODE_HSOK : sbsa_pkg::CODE_ERR;
      end else begin
         act_byte = ack_match ? sbsa_pkg::CODE_OK : sbsa_pkg::CODE_ERR;
      end

      acc = start_ok || file_ok || eof_ok || rx_send || rx_wait || rx_ackd;

      rsp_in.tx_valid = act_tx || emit;
      rsp_in.tx_byte  = act_tx ? act_byte : (emit ? blk_byte : 8'h00);
      rsp_in.accepted = acc;
      rsp_in.status   = phase_in;

      fill_in    = fill_ff;
      pos_in     = pos_ff;
      csum_in    = csum_ff;
      final_in   = final_ff;
      closing_in = closing_ff;
      ackp_in    = ackp_ff;
      ackx_in    = ackx_ff;
      wr_en      = fire && file_ok;

      if (fire) begin
         if (start_ok) begin
            fill_in    = '0;
            final_in   = 1'b0;
            closing_in = 1'b0;
            ackp_in    = 2'd0;
            ackx_in    = 8'h00;
            pos_in     = '0;
            csum_in    = 8'h00;
         end
         if (file_ok) begin
            fill_in = fill_sum[FW-1:0];
         end
         if (eof_ok) begin
            final_in = 1'b1;
         end
         if (begin_blk) begin
            pos_in  = '0;
            csum_in = 8'h00;
         end
         if (rx_wait && cmd.rx_hsok) begin
            ackp_in = 2'd0;
            ackx_in = 8'h00;
         end
         if (rx_ackd && !ack_final) begin
            ackx_in = ackx_ff ^ cmd.data;
            ackp_in = ackp_ff + 2'd1;
         end
         if (ack_final) begin
            ackp_in = 2'd0;
            if (ack_match) begin
               fill_in = '0;
               if (final_ff) begin
                  closing_in = 1'b1;
               end
            end
         end
         if (emit) begin
            if (last_emit) begin
               pos_in = '0;
            end else begin
               csum_in = csum_cur ^ blk_byte;
               pos_in  = pos_cur + PW'(1);
            end
         end
      end

      // prefetch the payload byte for the position that comes next
      pos_m1 = pos_in - PW'(1);
      raddr  = pos_m1[AW-1:0];

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sbsa_pkg::PH_IDLE;
         fill_ff      <= '0;
         pos_ff       <= '0;
         csum_ff      <= 8'h00;
         final_ff     <= 1'b0;
         closing_ff   <= 1'b0;
         ackp_ff      <= 2'd0;
         ackx_ff      <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         csum_ff      <= csum_in;
         final_ff     <= final_in;
         closing_ff   <= closing_in;
         ackp_ff      <= ackp_in;
         ackx_ff      <= ackx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[AW-1:0]] <= cmd.data;
      end
      // a byte written in this cycle goes straight to the read register
      if (wr_en && (fill_ff[AW-1:0] == raddr)) begin
         rd_data_ff <= cmd.data;
      end else begin
         rd_data_ff <= mem[raddr];
      end
   end

endmodule

/* sv/serial_block_sender_with_ack.sv */
// Block sender for a serial link with per-block acknowledgement.
// Request channel (req_valid/req_ready/req_data): one event per request,
// either a start, a file byte, end of file, or a byte received from the
// client, together with the transmitter's ready flag.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, in order, carrying the byte to send (if any), whether the request
// was taken in the current phase, and the phase after it.
// A request is registered in the decode queue, the back end executes it
// when it leaves the queue, and its response then waits in the output
// register.
// Throughput is one request per cycle while the receiver takes responses;
// the phase, position and checksum registers are updated per request, and
// the payload memory is read ahead into a register for the byte it supplies.
// Reset clears the phase to idle and empties the queue and output register;
// the payload memory needs no clearing since every byte read was written in
// the same block.
// When the receiver stalls the response is held, the queue fills within two
// requests and req_ready then drops until responses drain.
module serial_block_sender_with_ack #(
   parameter int BLOCK_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbsa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbsa_pkg::rsp_type rsp_data
);

   sbsa_pkg::cmd_type dec_cmd, q_cmd;
   logic q_valid, q_take;

   sbsa_front u_front (
      .req (req_data),
      .cmd (dec_cmd)
   );

   sbsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (dec_cmd),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_cmd   (q_cmd)
   );

   sbsa_back #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_take  (q_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !q_valid))
      else $error("reset left work pending");

   a_quiet_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.tx_valid || rsp_data.tx_byte == 8'h00))
      else $error("byte field nonzero without tx_valid");

   a_stall_holds_queue : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_take)
      else $error("queue popped while response stalled");

endmodule

/* tb/testbench.sv */
module testbench;

   localparam int BLK            = 128;
   localparam int BW             = $clog2(BLK);
   localparam int RANDOM_ITEMS   = 480;
   localparam int NOISE_ITEMS    = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sbsa_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sbsa_pkg::rsp_type rsp_data;

   serial_block_sender_with_ack #(.BLOCK_BYTES(BLK)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the sender state
   sbsa_pkg::phase_type ph = sbsa_pkg::PH_IDLE;
   logic [7:0] payload [BLK];
   logic [7:0] fill_cnt  = '0;
   logic [8:0] send_pos  = '0;
   logic [7:0] run_xor   = '0;
   logic       last_data = 1'b0;
   logic       closing   = 1'b0;
   logic [1:0] ack_cnt   = '0;
   logic [7:0] ack_sum   = '0;

   sbsa_pkg::rsp_type expected_rsp [$];

   int errors      = 0;
   int n_requests  = 0;
   int n_useful    = 0;
   int n_checked   = 0;
   int n_acked     = 0;
   int n_done      = 0;
   int n_broken    = 0;
   int quiet_cycles = 0;
   int rsp_stall   = 0;
   int calm_left [2] = '{0, 0};

   function automatic void start_block();
      send_pos = '0;
      run_xor  = '0;
      ph       = sbsa_pkg::PH_SEND;
   endfunction

   function automatic sbsa_pkg::rsp_type predict_step(input sbsa_pkg::req_type r);
      sbsa_pkg::rsp_type o;
      logic [7:0] b;
      logic [8:0] k;
      logic       aborted;
      o       = '0;
      aborted = 1'b0;
      case (r.action)
         sbsa_pkg::ACT_START: begin
            if (ph == sbsa_pkg::PH_IDLE || ph == sbsa_pkg::PH_DONE ||
                ph == sbsa_pkg::PH_ABORT || ph == sbsa_pkg::PH_FAIL) begin
               o.accepted = 1'b1;
               ph         = sbsa_pkg::PH_FILL;
               fill_cnt   = '0;
               last_data  = 1'b0;
               closing    = 1'b0;
               ack_cnt    = '0;
               ack_sum    = '0;
               send_pos   = '0;
               run_xor    = '0;
            end
         end
         sbsa_pkg::ACT_FILE: begin
            if (ph == sbsa_pkg::PH_FILL) begin
               o.accepted = 1'b1;
               b = (r.data == sbsa_pkg::CHAR_LF) ? sbsa_pkg::CHAR_CR : r.data;
               if (fill_cnt < BLK) payload[fill_cnt[BW-1:0]] = b;
               fill_cnt++;
               // a full block goes out before end of file is known
               if (fill_cnt >= BLK) start_block();
            end
         end
         sbsa_pkg::ACT_EOF: begin
            if (ph == sbsa_pkg::PH_FILL) begin
               o.accepted = 1'b1;
               last_data  = 1'b1;
               start_block();
            end
         end
         default: begin
            if (ph == sbsa_pkg::PH_SEND) begin
               o.accepted = 1'b1;
               if (r.data == sbsa_pkg::CODE_ERR) begin
                  ph      = sbsa_pkg::PH_ABORT;
                  aborted = 1'b1;
                  n_broken++;
               end
            end else if (ph == sbsa_pkg::PH_WAIT) begin
               o.accepted = 1'b1;
               o.tx_valid = 1'b1;
               if (r.data == sbsa_pkg::CODE_HSOK) begin
                  o.tx_byte = sbsa_pkg::CODE_HSOK;
                  ph        = sbsa_pkg::PH_ACKD;
                  ack_cnt   = '0;
                  ack_sum   = '0;
               end else begin
                  o.tx_byte = sbsa_pkg::CODE_ERR;
                  ph        = sbsa_pkg::PH_FAIL;
                  n_broken++;
               end
            end else if (ph == sbsa_pkg::PH_ACKD) begin
               o.accepted = 1'b1;
               if (ack_cnt < sbsa_pkg::ACK_BYTES) begin
                  ack_sum ^= r.data;
                  ack_cnt++;
               end else begin
                  o.tx_valid = 1'b1;
                  ack_cnt    = '0;
                  if (r.data == ack_sum) begin
                     o.tx_byte = sbsa_pkg::CODE_OK;
                     fill_cnt  = '0;
                     n_acked++;
                     if (last_data) begin
                        closing = 1'b1;
                        start_block();
                     end else begin
                        ph = sbsa_pkg::PH_FILL;
                     end
                  end else begin
                     o.tx_byte = sbsa_pkg::CODE_ERR;
                     ph        = sbsa_pkg::PH_FAIL;
                     n_broken++;
                  end
               end
            end
         end
      endcase

      // transmitter slot: only when nothing else went out this request
      if (!aborted && !o.tx_valid && r.tx_ready && ph == sbsa_pkg::PH_SEND) begin
         o.tx_valid = 1'b1;
         if (send_pos > BLK) begin
            o.tx_byte = run_xor;
            send_pos  = '0;
            if (closing) begin
               ph = sbsa_pkg::PH_DONE;
               n_done++;
            end else begin
               ph = sbsa_pkg::PH_WAIT;
            end
         end else begin
            if (send_pos == 9'd0) begin
               b = closing ? sbsa_pkg::FLAG_LAST : sbsa_pkg::FLAG_DATA;
            end else begin
               k = send_pos - 9'd1;
               if (k < {1'b0, fill_cnt}) b = payload[k[BW-1:0]];
               else b = sbsa_pkg::CODE_PAD;
            end
            o.tx_byte = b;
            run_xor  ^= b;
            send_pos++;
         end
      end
      o.status = ph;
      return o;
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int idle_gap(input logic side);
      int r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = int'($urandom_range(0, 99));
      if (r < 3) begin
         calm_left[side] = int'($urandom_range(20, 100));
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 40));
   endfunction

   task automatic send_req(input logic [1:0] act, input logic [7:0] d, input logic rdy);
      int                gap;
      sbsa_pkg::req_type r;
      sbsa_pkg::rsp_type want;
      r.action   = act;
      r.data     = d;
      r.tx_ready = rdy;
      gap = idle_gap(1'b0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = predict_step(r);
      expected_rsp.push_back(want);
      n_requests++;
      if (want.accepted || want.tx_valid) n_useful++;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_response(input sbsa_pkg::rsp_type got);
      sbsa_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         $display("%0t: response with no request pending, got %h", $time, got);
         errors++;
      end else begin
         want = expected_rsp.pop_front();
         compare_field("tx_valid", int'(want.tx_valid), int'(got.tx_valid));
         compare_field("tx_byte", int'(want.tx_byte), int'(got.tx_byte));
         compare_field("accepted", int'(want.accepted), int'(got.accepted));
         compare_field("status", int'(want.status), int'(got.status));
         n_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = idle_gap(1'b1);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, expected_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // start is ignored in every phase this is used in
   task automatic send_ignored();
      send_req(sbsa_pkg::ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // drive requests until the block being sent is finished or aborted
   task automatic pump_block(input int abort_at);
      int         step;
      logic [1:0] act;
      logic [7:0] d;
      step = 0;
      while (ph == sbsa_pkg::PH_SEND) begin
         if (step == abort_at) begin
            send_req(sbsa_pkg::ACT_RX, sbsa_pkg::CODE_ERR, 1'($urandom_range(0, 1)));
         end else begin
            act = 2'($urandom_range(0, 3));
            d   = 8'($urandom_range(0, 255));
            if (act == sbsa_pkg::ACT_RX && d == sbsa_pkg::CODE_ERR) d = ~d;
            send_req(act, d, $urandom_range(0, 4) != 0);
         end
         step++;
      end
   endtask

   task automatic test_out_of_phase();
      send_req(sbsa_pkg::ACT_FILE, 8'hFF, 1'b1);
      send_req(sbsa_pkg::ACT_EOF, 8'h00, 1'b1);
      send_req(sbsa_pkg::ACT_RX, sbsa_pkg::CODE_ERR, 1'b1);
      send_req(sbsa_pkg::ACT_RX, sbsa_pkg::CODE_HSOK, 1'b0);
      send_req(sbsa_pkg::ACT_START, 8'h00, 1'b0);
      send_req(sbsa_pkg::ACT_START, 8'hFF, 1'b1);
      send_req(sbsa_pkg::ACT_RX, sbsa_pkg::CODE_HSOK, 1'b1);
   endtask

   task automatic test_newline_and_abort();
      send_req(sbsa_pkg::ACT_FILE, sbsa_pkg::CHAR_LF, 1'b0);
      send_req(sbsa_pkg::ACT_FILE, 8'h00, 1'b1);
      send_req(sbsa_pkg::ACT_FILE, 8'hFF, 1'b0);
      send_req(sbsa_pkg::ACT_FILE, sbsa_pkg::CHAR_CR, 1'b1);
      send_req(sbsa_pkg::ACT_EOF, 8'hFF, 1'b1);
      send_req(sbsa_pkg::ACT_RX, 8'h55, 1'b1);
      send_req(sbsa_pkg::ACT_RX, 8'hAA, 1'b0);
      send_req(sbsa_pkg::ACT_FILE, 8'h12, 1'b1);
      send_req(sbsa_pkg::ACT_START, 8'h00, 1'b1);
      send_req(sbsa_pkg::ACT_RX, sbsa_pkg::CODE_ERR, 1'b1);
      send_req(sbsa_pkg::ACT_RX, 8'h00, 1'b1);
      send_req(sbsa_pkg::ACT_EOF, 8'h00, 1'b1);
   endtask

   task automatic random_transfer();
      int         fate;
      int         full_blocks;
      int         blk;
      int         n;
      int         i;
      logic       is_last;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] chk;
      fate        = int'($urandom_range(0, 19));
      full_blocks = ($urandom_range(0, 4) == 0) ? 1 : 0;
      send_req(sbsa_pkg::ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (blk = 0; blk <= full_blocks; blk++) begin
         is_last = (blk == full_blocks);
         if (!is_last) n = BLK;
         else if ($urandom_range(0, 5) == 0) n = 0;
         else if ($urandom_range(0, 9) == 0) n = BLK - 1;
         else n = int'($urandom_range(1, 40));
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_ignored();
            send_req(sbsa_pkg::ACT_FILE,
                     ($urandom_range(0, 7) == 0) ? sbsa_pkg::CHAR_LF
                                                 : 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
         end
         if (is_last) begin
            send_req(sbsa_pkg::ACT_EOF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         pump_block((fate < 4) ? int'($urandom_range(0, 140)) : -1);
         if (ph != sbsa_pkg::PH_WAIT) return;
         if ($urandom_range(0, 3) == 0) send_ignored();
         a = (fate >= 4 && fate < 7) ? 8'($urandom_range(0, 255)) : sbsa_pkg::CODE_HSOK;
         if (fate >= 4 && fate < 7 && a == sbsa_pkg::CODE_HSOK) a = ~a;
         send_req(sbsa_pkg::ACT_RX, a, 1'($urandom_range(0, 1)));
         if (ph != sbsa_pkg::PH_ACKD) return;
         a   = 8'($urandom_range(0, 255));
         b   = 8'($urandom_range(0, 255));
         chk = a ^ b;
         if (fate >= 7 && fate < 10) chk ^= 8'($urandom_range(1, 255));
         send_req(sbsa_pkg::ACT_RX, a, 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0) send_ignored();
         send_req(sbsa_pkg::ACT_RX, b, 1'($urandom_range(0, 1)));
         send_req(sbsa_pkg::ACT_RX, chk, 1'($urandom_range(0, 1)));
         if (ph == sbsa_pkg::PH_FAIL) return;
      end
      // closing block
      pump_block((fate < 4) ? int'($urandom_range(0, 140)) : -1);
   endtask

   task automatic test_random_transfers();
      while (n_requests < RANDOM_ITEMS) random_transfer();
   endtask

   task automatic test_random_noise();
      int i;
      for (i = 0; i < NOISE_ITEMS; i++) begin
         send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_out_of_phase();
      test_newline_and_abort();
      test_random_transfers();
      test_random_noise();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("sent %0d requests (%0d doing work), checked %0d responses",
               n_requests, n_useful, n_checked);
      $display("%0d blocks acknowledged, %0d transfers finished, %0d aborted or refused",
               n_acked, n_done, n_broken);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
